FILE: design/rsm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the range set block.
package rsm_pkg;

    localparam int FIELD_W      = 63;
    localparam int FUNC_W       = 2;
    localparam int TOTAL_W      = 11;
    localparam int HITS_W       = 32;
    localparam int S_TDATA_W    = 192;
    localparam int M_TDATA_W    = 48;
    localparam int MAX_RANGES_D = 1024;
    localparam int ID_BITS_D    = 63;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic raw_append;
        logic mrg_clear;
        logic sort_init;
        logic key_rd;
        logic key_cap;
        logic cmp_step;
        logic mrg_rd0;
        logic mrg_first;
        logic mrg_step;
        logic mrg_last;
        logic srch_start;
        logic srch_step;
        logic finish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              raw_empty;
        logic              raw_one;
        logic              mrg_empty;
        logic              place;
        logic              i_end;
        logic              next_end;
        logic              srch_more;
        logic              out_free;
    } sts_t;

endpackage

FILE: design/range_set_membership.sv
// Range set membership: load ranges into a 1024-entry store, build a sorted merged list by
// in-place stable insertion sort and a merge sweep (n squared / 2 shifts at worst, one raw store
// write per compare step), and query by binary search over the merged store; each item gives
// one result item, and each store has a single read port.
module range_set_membership
#(
    parameter int MAX_RANGES = rsm_pkg::MAX_RANGES_D,
    parameter int ID_BITS    = rsm_pkg::ID_BITS_D
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsm_pkg::S_TDATA_W-1:0] s_tdata,  // range_start, range_end, query_id, pad
    input  logic [rsm_pkg::FUNC_W-1:0]    s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rsm_pkg::M_TDATA_W-1:0] m_tdata   // status, is_member, merged_total,
                                                    // hits_so_far, pad
);
    import rsm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsm_dp
    #(
        .MAX_RANGES (MAX_RANGES),
        .ID_BITS    (ID_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

FILE: design/rsm_ctrl.sv
// Sequencer for load, build (sort and merge) and query items.
module rsm_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rsm_pkg::sts_t sts,
    output rsm_pkg::cmd_t cmd
);
    import rsm_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DISP    = 4'd1;
    localparam logic [3:0] ST_KEY_RD  = 4'd2;
    localparam logic [3:0] ST_KEY_CAP = 4'd3;
    localparam logic [3:0] ST_CMP     = 4'd4;
    localparam logic [3:0] ST_M_RD0   = 4'd5;
    localparam logic [3:0] ST_M_FIRST = 4'd6;
    localparam logic [3:0] ST_M_STEP  = 4'd7;
    localparam logic [3:0] ST_M_LAST  = 4'd8;
    localparam logic [3:0] ST_SR_CMP  = 4'd9;
    localparam logic [3:0] ST_FINISH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (sts.func)
                    FUNC_LOAD:
                    begin
                        cmd.raw_append = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    FUNC_BUILD:
                    begin
                        if (sts.raw_empty)
                        begin
                            cmd.mrg_clear = 1'b1;
                            state_next    = ST_FINISH;
                        end
                        else if (sts.raw_one)
                        begin
                            state_next = ST_M_RD0;
                        end
                        else
                        begin
                            cmd.sort_init = 1'b1;
                            state_next    = ST_KEY_RD;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        cmd.srch_start = 1'b1;
                        state_next     = sts.mrg_empty ? ST_FINISH : ST_SR_CMP;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_KEY_RD:
            begin
                cmd.key_rd = 1'b1;
                state_next = ST_KEY_CAP;
            end
            ST_KEY_CAP:
            begin
                cmd.key_cap = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (sts.place)
                begin
                    state_next = sts.next_end ? ST_M_RD0 : ST_KEY_RD;
                end
            end
            ST_M_RD0:
            begin
                cmd.mrg_rd0 = 1'b1;
                state_next  = ST_M_FIRST;
            end
            ST_M_FIRST:
            begin
                cmd.mrg_first = 1'b1;
                state_next    = sts.i_end ? ST_M_LAST : ST_M_STEP;
            end
            ST_M_STEP:
            begin
                cmd.mrg_step = 1'b1;
                if (sts.next_end)
                begin
                    state_next = ST_M_LAST;
                end
            end
            ST_M_LAST:
            begin
                cmd.mrg_last = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_SR_CMP:
            begin
                cmd.srch_step = 1'b1;
                if (!sts.srch_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/rsm_dp.sv
// Datapath: raw and merged range stores, sort/merge/search registers, result register.
module rsm_dp
#(
    parameter int MAX_RANGES = rsm_pkg::MAX_RANGES_D,
    parameter int ID_BITS    = rsm_pkg::ID_BITS_D
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rsm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rsm_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rsm_pkg::M_TDATA_W-1:0] m_tdata,
    input  rsm_pkg::cmd_t                 cmd,
    output rsm_pkg::sts_t                 sts
);
    import rsm_pkg::*;

    localparam int IDW = ID_BITS;
    localparam int AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW  = $clog2(MAX_RANGES + 1);
    localparam int PW  = 2 * IDW;

    // stores hold {end, start}
    logic [PW-1:0] raw_mem [MAX_RANGES];
    logic [PW-1:0] mrg_mem [MAX_RANGES];

    logic [PW-1:0] raw_rdata_reg;
    logic [PW-1:0] mrg_rdata_reg;
    logic          raw_we;
    logic [AW-1:0] raw_waddr;
    logic [PW-1:0] raw_wdata;
    logic [AW-1:0] raw_raddr;
    logic          mrg_we;
    logic [AW-1:0] mrg_waddr;
    logic [AW-1:0] mrg_raddr;

    logic [FUNC_W-1:0] func_reg;
    logic [IDW-1:0]    start_reg;
    logic [IDW-1:0]    end_reg;
    logic [IDW-1:0]    query_reg;
    logic [CW-1:0]     raw_cnt_reg;
    logic [CW-1:0]     mrg_cnt_reg;
    logic [HITS_W-1:0] hits_reg;
    logic [HITS_W-1:0] hits_next;
    logic              status_reg;
    logic              member_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [PW-1:0]     key_reg;
    logic [PW-1:0]     cur_reg;
    logic [AW-1:0]     m_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     mid_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [IDW-1:0] rd_start;
    logic [IDW-1:0] rd_end;
    logic [IDW-1:0] cur_end;
    logic [IDW:0]   cur_end_p1;
    logic           raw_full;
    logic           place;
    logic [IDW-1:0] ms;
    logic [IDW-1:0] me;
    logic           hit;
    logic [CW-1:0]  lo_n;
    logic [CW-1:0]  hi_n;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_n;
    logic [CW-1:0]  mid0;

    assign rd_start   = raw_rdata_reg[IDW-1:0];
    assign rd_end     = raw_rdata_reg[PW-1:IDW];
    assign cur_end    = cur_reg[PW-1:IDW];
    assign cur_end_p1 = {1'b0, cur_end} + {{IDW{1'b0}}, 1'b1};
    assign raw_full   = (raw_cnt_reg == CW'(MAX_RANGES));
    assign place      = (j_reg == '0) || !(rd_start > key_reg[IDW-1:0]);

    assign ms      = mrg_rdata_reg[IDW-1:0];
    assign me      = mrg_rdata_reg[PW-1:IDW];
    assign hit     = (query_reg >= ms) && (query_reg <= me);
    assign lo_n    = (query_reg < ms) ? lo_reg : mid_reg + CW'(1);
    assign hi_n    = (query_reg < ms) ? mid_reg : hi_reg;
    assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    assign mid_n   = mid_sum[CW:1];
    assign mid0    = mrg_cnt_reg >> 1;

    always_comb
    begin
        sts.func      = func_reg;
        sts.raw_empty = (raw_cnt_reg == '0);
        sts.raw_one   = (raw_cnt_reg == CW'(1));
        sts.mrg_empty = (mrg_cnt_reg == '0);
        sts.place     = place;
        sts.i_end     = (i_reg >= raw_cnt_reg);
        sts.next_end  = ({1'b0, i_reg} + {{CW{1'b0}}, 1'b1}) >= {1'b0, raw_cnt_reg};
        sts.srch_more = !hit && (lo_n < hi_n);
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // raw store ports
    always_comb
    begin
        raw_we    = 1'b0;
        raw_waddr = raw_cnt_reg[AW-1:0];
        raw_wdata = {end_reg, start_reg};
        raw_raddr = i_reg[AW-1:0];
        if (cmd.raw_append && !raw_full)
        begin
            raw_we = 1'b1;
        end
        if (cmd.cmp_step)
        begin
            raw_we    = 1'b1;
            raw_waddr = j_reg[AW-1:0];
            raw_wdata = place ? key_reg : raw_rdata_reg;
            raw_raddr = AW'(j_reg - CW'(2));
        end
        if (cmd.key_cap)
        begin
            raw_raddr = AW'(i_reg - CW'(1));
        end
        if (cmd.mrg_rd0)
        begin
            raw_raddr = '0;
        end
        if (cmd.mrg_step)
        begin
            raw_raddr = AW'(i_reg + CW'(1));
        end
    end

    always_comb
    begin
        mrg_we    = 1'b0;
        mrg_waddr = m_reg;
        mrg_raddr = mid0[AW-1:0];
        if (cmd.srch_step)
        begin
            mrg_raddr = mid_n[AW-1:0];
        end
        if (cmd.mrg_last || (cmd.mrg_step && !(rd_start <= cur_end_p1)))
        begin
            mrg_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_mem[raw_waddr] <= raw_wdata;
        end
        raw_rdata_reg <= raw_mem[raw_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mrg_we)
        begin
            mrg_mem[mrg_waddr] <= cur_reg;
        end
        mrg_rdata_reg <= mrg_mem[mrg_raddr];
    end

    // item fields and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= s_tuser;
            start_reg <= s_tdata[IDW-1:0];
            end_reg   <= s_tdata[FIELD_W +: IDW];
            query_reg <= s_tdata[2*FIELD_W +: IDW];
        end
        if (cmd.sort_init)
        begin
            i_reg <= CW'(1);
        end
        if (cmd.key_rd)
        begin
            j_reg <= i_reg;
        end
        if (cmd.key_cap)
        begin
            key_reg <= raw_rdata_reg;
        end
        if (cmd.cmp_step)
        begin
            if (place)
            begin
                i_reg <= i_reg + CW'(1);
            end
            else
            begin
                j_reg <= j_reg - CW'(1);
            end
        end
        if (cmd.mrg_rd0)
        begin
            i_reg <= CW'(1);
        end
        if (cmd.mrg_first)
        begin
            cur_reg <= raw_rdata_reg;
            m_reg   <= '0;
        end
        if (cmd.mrg_step)
        begin
            i_reg <= i_reg + CW'(1);
            if (rd_start <= cur_end_p1)
            begin
                if (rd_end > cur_end)
                begin
                    cur_reg[PW-1:IDW] <= rd_end;
                end
            end
            else
            begin
                cur_reg <= raw_rdata_reg;
                m_reg   <= m_reg + AW'(1);
            end
        end
        if (cmd.srch_start)
        begin
            lo_reg  <= '0;
            hi_reg  <= mrg_cnt_reg;
            mid_reg <= mid0;
        end
        if (cmd.srch_step)
        begin
            lo_reg  <= lo_n;
            hi_reg  <= hi_n;
            mid_reg <= mid_n;
        end
        if (cmd.finish)
        begin
            m_data_reg <= M_TDATA_W'({hits_next, TOTAL_W'(mrg_cnt_reg), member_reg, status_reg});
        end
    end

    assign hits_next = (member_reg && (hits_reg != {HITS_W{1'b1}})) ?
                       hits_reg + HITS_W'(1) : hits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_cnt_reg <= '0;
            mrg_cnt_reg <= '0;
            hits_reg    <= '0;
            status_reg  <= 1'b0;
            member_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                status_reg <= 1'b0;
                member_reg <= 1'b0;
            end
            if (cmd.raw_append)
            begin
                if (raw_full)
                begin
                    status_reg <= 1'b1;
                end
                else
                begin
                    raw_cnt_reg <= raw_cnt_reg + CW'(1);
                end
            end
            if (cmd.mrg_clear)
            begin
                mrg_cnt_reg <= '0;
            end
            if (cmd.mrg_last)
            begin
                mrg_cnt_reg <= CW'(m_reg) + CW'(1);
            end
            if (cmd.srch_step && hit)
            begin
                member_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                hits_reg    <= hits_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        raw_cnt_reg <= CW'(MAX_RANGES))
        else $error("raw count beyond store depth");

    a_mrg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mrg_cnt_reg <= raw_cnt_reg)
        else $error("merged count exceeds loaded count");

    a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> hits_reg == $past(hits_reg))
        else $error("hit counter moved outside result delivery");

endmodule
